// ===== hdl/srh_pkg.sv =====
// Shared types, constants and codes of the strided RGB histogram.
package srh_pkg;

  localparam int MAX_BINS_DEF = 256;
  localparam int NUM_CH       = 3;
  localparam int CNT_W        = 32;
  localparam int LEVEL_W      = 16;
  localparam int BINS_W       = 9;
  localparam int STRIDE_W     = 8;
  localparam int CHAN_W       = 2;
  localparam int RBIN_W       = 8;
  localparam int ACT_W        = 2;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [BINS_W-1:0]   BINS_RST   = 9'd256;
  localparam logic                FORMAT_RST = 1'b0;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 8'd31;

  // word opcodes
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_BINS   = 2'd0,
    REG_FORMAT = 2'd1,
    REG_STRIDE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_LOOKUP,
    ST_UPDATE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [BINS_W-1:0]   bins_in_use;
    logic                pixel_format;
    logic [STRIDE_W-1:0] sample_stride;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic clr_start;
    logic clr_wr;
    logic mul_en;
    logic div_en;
    logic fix_en;
    logic rd_en;
    logic rd_port;
    logic wr_inc;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    in_valid;
    action_t action;
    logic    sample;
    logic    clr_last;
    logic    out_free;
  } sts_t;

endpackage

// ===== hdl/srh_if.sv =====
// Input and result channel interfaces of the strided RGB histogram.
interface srh_in_if import srh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [LEVEL_W-1:0]  red_level;
  logic [LEVEL_W-1:0]  green_level;
  logic [LEVEL_W-1:0]  blue_level;
  logic [CHAN_W-1:0]   read_channel;
  logic [RBIN_W-1:0]   read_bin;

  modport source (output valid, action, red_level, green_level, blue_level,
                  read_channel, read_bin, input ready);
  modport sink   (input valid, action, red_level, green_level, blue_level,
                  read_channel, read_bin, output ready);
endinterface

interface srh_out_if import srh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] bin_total;

  modport source (output valid, bin_total, input ready);
  modport sink   (input valid, bin_total, output ready);
endinterface

// ===== hdl/srh_binner.sv =====
// Level-to-bin unit for one channel: multiply, divide step, correct and clamp.
module srh_binner import srh_pkg::*; (
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic [LEVEL_W-1:0] level,
  input  logic               fmt,
  input  logic [BINS_W-1:0]  nbins,
  output logic [BINS_W-1:0]  bin
);

  localparam int MANT_W = 11;
  localparam int PROD_W = MANT_W + BINS_W;
  localparam int Q_W    = BINS_W + 1;
  localparam int RCP_W  = PROD_W + 8;

  logic [4:0]        expo;
  logic [9:0]        frac;
  logic              is_nan;
  logic [MANT_W-1:0] mul_a;
  logic [4:0]        shift;

  logic [PROD_W-1:0] prod_r;
  logic [4:0]        shift_r;
  logic              zero_r;
  logic              max_r;
  logic [Q_W-1:0]    q_r;
  logic [BINS_W-1:0] bin_r;

  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] rem;
  logic [Q_W-1:0]    k;
  logic [Q_W-1:0]    bins_x;

  assign expo   = level[14:10];
  assign frac   = level[9:0];
  assign is_nan = (expo == 5'd31) && (frac != 10'd0);

  always_comb begin
    if (fmt) begin
      mul_a = (expo == 5'd0) ? {1'b0, frac} : {1'b1, frac};
      shift = (expo == 5'd0) ? 5'd24 : 5'd25 - expo;
    end else begin
      mul_a = {3'b0, level[7:0]};
      shift = 5'd0;
    end
  end

  // x/255 ~ (x*257) >> 16, low by at most one
  assign rcp    = {8'b0, prod_r} + {prod_r, 8'b0};
  assign rem    = prod_r - (PROD_W'({q_r, 8'b0}) - PROD_W'(q_r));
  assign bins_x = {1'b0, nbins};

  always_comb begin
    if (fmt) begin
      if (zero_r)     k = '0;
      else if (max_r) k = bins_x - Q_W'(1);
      else            k = q_r;
    end else begin
      k = (rem >= PROD_W'(255)) ? q_r + Q_W'(1) : q_r;
    end
    if (k >= bins_x) k = bins_x - Q_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r  <= {{BINS_W{1'b0}}, mul_a} * {{MANT_W{1'b0}}, nbins};
      shift_r <= shift;
      zero_r  <= level[15] || is_nan;
      max_r   <= (expo >= 5'd15);
    end
    if (cmd.div_en) begin
      if (fmt) q_r <= Q_W'(prod_r >> shift_r);
      else     q_r <= Q_W'(rcp >> 16);
    end
    if (cmd.fix_en) bin_r <= BINS_W'(k);
  end

  assign bin = bin_r;

endmodule

// ===== hdl/srh_dp.sv =====
// Datapath: stride phase, counter banks, clear sweep and result register.
module srh_dp import srh_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  cmd_t          cmd,
  output sts_t          sts,
  srh_in_if.sink        in_ch,
  srh_out_if.source     out_ch
);

  localparam int BIN_W = $clog2(MAX_BINS);

  logic [CNT_W-1:0]    cnt_mem_r [NUM_CH][MAX_BINS];
  logic [CNT_W-1:0]    rdata_r   [NUM_CH];

  logic [STRIDE_W-1:0] phase_r, phase_nxt;
  logic [BIN_W-1:0]    clr_cnt_r;
  logic [CHAN_W-1:0]   rd_chan_r;
  logic                rd_ok_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    out_total_r;

  logic [LEVEL_W-1:0]  level   [NUM_CH];
  logic [BINS_W-1:0]   bin     [NUM_CH];
  logic [BIN_W-1:0]    rd_addr [NUM_CH];
  logic [BIN_W-1:0]    wr_addr [NUM_CH];
  logic [CNT_W-1:0]    wr_data [NUM_CH];
  logic                mem_we;

  logic [BINS_W-1:0]   bins_eff;
  logic [STRIDE_W-1:0] stride_eff;
  logic [STRIDE_W-1:0] phase_inc;
  logic                pixel_in;
  logic                read_in;
  logic [CNT_W-1:0]    reply;

  assign level[0] = in_ch.red_level;
  assign level[1] = in_ch.green_level;
  assign level[2] = in_ch.blue_level;

  always_comb begin
    if (cfg.bins_in_use == '0)
      bins_eff = BINS_W'(1);
    else if (32'(cfg.bins_in_use) > 32'(MAX_BINS))
      bins_eff = BINS_W'(MAX_BINS);
    else
      bins_eff = cfg.bins_in_use;
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    srh_binner u_binner (
      .clk   (clk),
      .cmd   (cmd),
      .level (level[c]),
      .fmt   (cfg.pixel_format),
      .nbins (bins_eff),
      .bin   (bin[c])
    );
  end

  assign pixel_in = cmd.accept && (action_t'(in_ch.action) == ACT_PIXEL);
  assign read_in  = cmd.accept && (action_t'(in_ch.action) == ACT_READ);

  assign stride_eff = (cfg.sample_stride == '0) ? STRIDE_W'(1) : cfg.sample_stride;
  assign phase_inc  = phase_r + STRIDE_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    if (cmd.clr_start)
      phase_nxt = '0;
    else if (pixel_in)
      phase_nxt = (phase_inc >= stride_eff) ? '0 : phase_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (cmd.clr_wr)
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + BIN_W'(1);
      if (cmd.out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  // counter banks: one write and one read port each
  assign mem_we = cmd.clr_wr || cmd.wr_inc;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rd_addr[c] = cmd.rd_port ? BIN_W'(in_ch.read_bin) : BIN_W'(bin[c]);
      wr_addr[c] = cmd.clr_wr ? clr_cnt_r : BIN_W'(bin[c]);
      if (cmd.clr_wr)
        wr_data[c] = '0;
      else if (rdata_r[c] == '1)
        wr_data[c] = rdata_r[c];
      else
        wr_data[c] = rdata_r[c] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (mem_we) cnt_mem_r[c][wr_addr[c]] <= wr_data[c];
      if (cmd.rd_en) rdata_r[c] <= cnt_mem_r[c][rd_addr[c]];
    end
  end

  always_ff @(posedge clk) begin
    if (read_in) begin
      rd_chan_r <= in_ch.read_channel;
      rd_ok_r   <= (in_ch.read_channel < CHAN_W'(NUM_CH)) &&
                   (32'(in_ch.read_bin) < 32'(MAX_BINS));
    end
    if (cmd.out_load) out_total_r <= reply;
  end

  always_comb begin
    case (rd_chan_r)
      2'd0:    reply = rdata_r[0];
      2'd1:    reply = rdata_r[1];
      2'd2:    reply = rdata_r[2];
      default: reply = '0;
    endcase
    if (!rd_ok_r) reply = '0;
  end

  assign in_ch.ready      = cmd.in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_total = out_total_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.action   = action_t'(in_ch.action);
  assign sts.sample   = (phase_r == '0);
  assign sts.clr_last = (clr_cnt_r == BIN_W'(MAX_BINS - 1));
  assign sts.out_free = !out_valid_r || out_ch.ready;

endmodule

// ===== hdl/srh_ctrl.sv =====
// Controller: sequences clear sweeps, pixel binning and counter reads.
module srh_ctrl import srh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (sts.in_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.action)
            ACT_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            ACT_PIXEL: begin
              if (sts.sample) begin
                cmd.mul_en = 1'b1;
                state_nxt  = ST_DIV;
              end
            end
            ACT_READ: begin
              cmd.rd_en   = 1'b1;
              cmd.rd_port = 1'b1;
              state_nxt   = ST_REPLY;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_nxt  = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.wr_inc = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/strided_rgb_histogram.sv =====
// Top level of the strided RGB histogram: register port, controller, datapath.
//
// Per-channel RGB histogram over a word stream. Each input word is a clear,
// a pixel or a read. A pixel is binned only when the stride phase is zero
// (first pixel after reset or clear, then one in sample_stride); its three
// levels go through a level-to-bin unit (multiply, divide by 255 or shift,
// correct/clamp) and a read-modify-write of three banks of MAX_BINS 32-bit
// saturating counters, each bank with one read and one write port. A sampled
// pixel steps through accept, two bin steps, bank read and bank write; a
// skipped pixel or an unknown opcode is only accepted; a read is accepted
// with its bank read and waits out any stall on the result channel, which
// holds one result word in an output register; after a clear is accepted, a
// sweep zeroes one row of all three banks per cycle, also after reset, and
// no input word is taken during a sweep. Registers (APB, 4-byte spaced):
// 0 bins_in_use, 1 pixel_format, 2 sample_stride; write them only while idle.
module strided_rgb_histogram import srh_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  srh_in_if.sink             in_ch,
  srh_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg_r, cfg_nxt;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t reg_idx;
  logic     reg_wr;

  // ---- register port ------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      unique case (reg_idx)
        REG_BINS:   cfg_nxt.bins_in_use   = pwdata[BINS_W-1:0];
        REG_FORMAT: cfg_nxt.pixel_format  = pwdata[0];
        REG_STRIDE: cfg_nxt.sample_stride = pwdata[STRIDE_W-1:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bins_in_use   <= BINS_RST;
      cfg_r.pixel_format  <= FORMAT_RST;
      cfg_r.sample_stride <= STRIDE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BINS:   prdata = PDATA_W'(cfg_r.bins_in_use);
      REG_FORMAT: prdata = PDATA_W'(cfg_r.pixel_format);
      REG_STRIDE: prdata = PDATA_W'(cfg_r.sample_stride);
      default:    prdata = '0;
    endcase
  end

  // ---- controller and datapath --------------------------------------------
  srh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  srh_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---- checks -------------------------------------------------------------
  // no word slips in while a clear sweep owns the banks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !cmd.clr_wr)
    else $error("word accepted during clear sweep");

  // a result word is only loaded when the output register can take it
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  // a sampled pixel reaches the bank write after its divide, fix and lookup steps
  a_pixel_writes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> ##4 cmd.wr_inc)
    else $error("sampled pixel lost before counter update");

  // bank lookup for a pixel follows the bin correction step
  a_lookup_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && !cmd.rd_port) |-> $past(cmd.fix_en))
    else $error("bank lookup without a fresh bin");

endmodule
